>>> hdl/b64sd_pkg.sv
// shared types for the base64 stream decoder
package b64sd_pkg;

    // character class decided by the front end
    typedef enum logic [1:0] {
        K_SKIP = 2'd0,
        K_SYM  = 2'd1,
        K_PAD  = 2'd2,
        K_BAD  = 2'd3
    } t_kind;

    // one classified character on its way to the back end
    typedef struct packed {
        t_kind       kind;
        logic [5:0]  value;
        logic        last;
    } t_sym_item;

    // one result item
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        byte_valid;
        logic        decode_error;
        logic        end_of_stream;
    } t_result;

endpackage

>>> hdl/b64sd_fifo.sv
// small register queue used between the stages and at the result side
module b64sd_fifo #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> hdl/b64sd_front.sv
// front end: alphabet register and character classification
module b64sd_front
    import b64sd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_url_safe,
    input  logic [7:0] i_character,
    input  logic       i_last_char,
    output t_sym_item  o_item
);

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    logic       r_url_safe;
    logic [7:0] c;
    logic [7:0] diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_url_safe <= 1'b0;
        end else if (i_cfg_valid) begin
            r_url_safe <= i_cfg_url_safe;
        end
    end

    assign c = i_character;

    always_comb begin
        o_item.kind  = K_BAD;
        o_item.value = '0;
        o_item.last  = i_last_char;
        diff         = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            // upper case letters: 0..25
            diff         = c - 8'h41;
            o_item.kind  = K_SYM;
            o_item.value = diff[5:0];
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            // lower case letters: 26..51
            diff         = c - 8'h47;
            o_item.kind  = K_SYM;
            o_item.value = diff[5:0];
        end else if (c >= 8'h30 && c <= 8'h39) begin
            // digits: 52..61
            diff         = c + 8'h04;
            o_item.kind  = K_SYM;
            o_item.value = diff[5:0];
        end else if ((r_url_safe && c == CH_MINUS) || (!r_url_safe && c == CH_PLUS)) begin
            o_item.kind  = K_SYM;
            o_item.value = 6'd62;
        end else if ((r_url_safe && c == CH_UNDER) || (!r_url_safe && c == CH_SLASH)) begin
            o_item.kind  = K_SYM;
            o_item.value = 6'd63;
        end else if (c == CH_EQ) begin
            o_item.kind  = K_PAD;
        end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
            o_item.kind  = K_SKIP;
        end
    end

endmodule

>>> hdl/b64sd_back.sv
// back end: bit accumulator, padding and error state, result generation
module b64sd_back
    import b64sd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_sym_item i_item,
    input  logic      i_item_valid,
    output logic      o_item_pop,
    output t_result   o_res,
    output logic      o_res_push,
    input  logic      i_res_full
);

    logic [11:0] r_acc, n_acc;
    logic [2:0]  r_pend, n_pend;
    logic        r_stopped, n_stopped;
    logic        r_error, n_error;
    logic        take, active, have_byte, new_err;
    logic [11:0] shifted;
    logic [7:0]  byte_out;

    assign take       = i_item_valid && !i_res_full;
    assign o_item_pop = take;
    assign active     = !r_stopped && !r_error;
    assign shifted    = {r_acc[5:0], i_item.value};

    always_comb begin
        n_acc     = r_acc;
        n_pend    = r_pend;
        n_stopped = r_stopped;
        n_error   = r_error;
        have_byte = 1'b0;
        new_err   = 1'b0;
        byte_out  = '0;
        if (active) begin
            case (i_item.kind)
                K_PAD: begin
                    n_stopped = 1'b1;
                end
                K_BAD: begin
                    n_error = 1'b1;
                    new_err = 1'b1;
                end
                K_SYM: begin
                    n_acc = shifted;
                    if (r_pend == 3'd0) begin
                        n_pend = 3'd6;
                    end else begin
                        n_pend    = r_pend - 3'd2;
                        have_byte = 1'b1;
                        case (r_pend)
                            3'd2:    byte_out = shifted[7:0];
                            3'd4:    byte_out = shifted[9:2];
                            default: byte_out = shifted[11:4];
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end
        // end of stream drops leftover bits and restarts
        if (i_item.last) begin
            n_acc     = '0;
            n_pend    = '0;
            n_stopped = 1'b0;
            n_error   = 1'b0;
        end
    end

    assign o_res_push           = take && (have_byte || new_err || i_item.last);
    assign o_res.data_byte      = byte_out;
    assign o_res.byte_valid     = have_byte;
    assign o_res.decode_error   = r_error || new_err;
    assign o_res.end_of_stream  = i_item.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_pend    <= '0;
            r_stopped <= 1'b0;
            r_error   <= 1'b0;
        end else if (take) begin
            r_acc     <= n_acc;
            r_pend    <= n_pend;
            r_stopped <= n_stopped;
            r_error   <= n_error;
        end
    end

endmodule

>>> hdl/base64_stream_decoder_top.sv
// top level of the streaming base64 decoder
// streaming base64 decoder, one text character per transfer, queue-style on both sides.
// a character is taken at every clock edge with i_push high and o_full low, so while
// results are popped the sustained rate is one character per cycle; the back end
// retires one classified character per cycle from the middle queue whenever the
// result queue has room. a result reaches the result ports through the middle queue
// and the result queue: the classifier is combinational and fills the middle queue at
// the accepting edge, and the back end moves the result into the result queue when it
// takes the item. characters that only feed bits, whitespace, and anything after
// '=' or an error give no result; the last character of a stream always gives one
// with o_end_of_stream set, and o_decode_error tells downstream to drop that stream.
// the alphabet register (0 standard, 1 url-safe) is written through the cfg channel,
// which is always ready; write it only while no stream is in flight.
module base64_stream_decoder_top
    import b64sd_pkg::*;
#(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // config write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_url_safe,
    // character input
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_character,
    input  logic       i_last_char,
    // result output
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_data_byte,
    output logic       o_byte_valid,
    output logic       o_decode_error,
    output logic       o_end_of_stream
);

    t_sym_item front_item;
    t_sym_item mid_item;
    logic      mid_empty;
    logic      mid_pop;
    t_result   back_res;
    logic      back_push;
    logic      out_full;
    t_result   out_res;

    // config transfers are always taken
    assign o_cfg_ready = 1'b1;

    // classify the incoming character
    b64sd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_url_safe (i_cfg_url_safe),
        .i_character    (i_character),
        .i_last_char    (i_last_char),
        .o_item         (front_item)
    );

    // decouples the classifier from the accumulator
    b64sd_fifo #(
        .WIDTH ($bits(t_sym_item)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (front_item),
        .o_full  (o_full),
        .i_pop   (mid_pop),
        .o_empty (mid_empty),
        .o_data  (mid_item)
    );

    // decode state and result generation
    b64sd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (mid_item),
        .i_item_valid (!mid_empty),
        .o_item_pop   (mid_pop),
        .o_res        (back_res),
        .o_res_push   (back_push),
        .i_res_full   (out_full)
    );

    // results wait here until popped
    b64sd_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_push),
        .i_data  (back_res),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (out_res)
    );

    assign o_data_byte     = out_res.data_byte;
    assign o_byte_valid    = out_res.byte_valid;
    assign o_decode_error  = out_res.decode_error;
    assign o_end_of_stream = out_res.end_of_stream;

endmodule

>>> hdl/b64sd_checker.sv
// port-level checks for the base64 stream decoder, bound to the top level
module b64sd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_valid,
    input logic       o_cfg_ready,
    input logic       i_cfg_url_safe,
    input logic       i_push,
    input logic       o_full,
    input logic [7:0] i_character,
    input logic       i_last_char,
    input logic       o_empty,
    input logic       i_pop,
    input logic [7:0] o_data_byte,
    input logic       o_byte_valid,
    input logic       o_decode_error,
    input logic       o_end_of_stream
);

    // every result carries a byte, an error or an end of stream
    a_result_meaningful: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_byte_valid || o_decode_error || o_end_of_stream))
        else $error("result with no content");

    // no byte means a zero data field
    a_idle_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_byte_valid) |-> (o_data_byte == 8'd0))
        else $error("data byte not zero without byte_valid");

    // a result waiting without pop stays put
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_data_byte)
            && $stable(o_byte_valid) && $stable(o_decode_error)
            && $stable(o_end_of_stream)))
        else $error("waiting result changed");

    // no result can exist right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> o_empty)
        else $error("result present after reset");

endmodule

bind base64_stream_decoder_top b64sd_checker u_checker (.*);

>>> test/base64_stream_decoder_top_tb.sv
// self-checking testbench for the streaming base64 decoder top level
module base64_stream_decoder_top_tb;
    import b64sd_pkg::*;

    // stimulus size and run limits
    localparam int          RANDOM_ITEMS  = 1000;
    localparam int          SETTLE_CYCLES = 16;     // covers the classifier, the back end and both queues
    localparam int          RESET_CYCLES  = 12;
    localparam int          MAX_REPORTS   = 10;
    localparam int          STREAMS_PER_PHASE = 12;
    localparam longint      RUN_LIMIT     = 2_000_000;

    // characters with a meaning of their own
    localparam logic [7:0]  CH_PAD   = 8'h3D;       // '='
    localparam logic [7:0]  CH_SPACE = 8'h20;
    localparam logic [7:0]  CH_TAB   = 8'h09;
    localparam logic [7:0]  CH_CR    = 8'h0D;
    localparam logic [7:0]  CH_LF    = 8'h0A;
    localparam logic [7:0]  CH_PLUS  = 8'h2B;
    localparam logic [7:0]  CH_SLASH = 8'h2F;
    localparam logic [7:0]  CH_MINUS = 8'h2D;
    localparam logic [7:0]  CH_UNDER = 8'h5F;

    // alphabet register values
    localparam logic        ALPHA_STD = 1'b0;
    localparam logic        ALPHA_URL = 1'b1;

    localparam int unsigned NO_BAD = 32'hFFFF_FFFF;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_url_safe;
    logic       i_push;
    logic       o_full;
    logic [7:0] i_character;
    logic       i_last_char;
    logic       o_empty;
    logic       i_pop;
    logic [7:0] o_data_byte;
    logic       o_byte_valid;
    logic       o_decode_error;
    logic       o_end_of_stream;

    base64_stream_decoder_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_url_safe  (i_cfg_url_safe),
        .i_push          (i_push),
        .o_full          (o_full),
        .i_character     (i_character),
        .i_last_char     (i_last_char),
        .o_empty         (o_empty),
        .i_pop           (i_pop),
        .o_data_byte     (o_data_byte),
        .o_byte_valid    (o_byte_valid),
        .o_decode_error  (o_decode_error),
        .o_end_of_stream (o_end_of_stream)
    );

    // decoder shadow state, advanced at every accepted character transfer
    logic [11:0] shadow_acc;
    logic [2:0]  shadow_pending;
    logic        shadow_stopped;
    logic        shadow_error;
    logic        alphabet_sel;

    // decoded results still owed by the block, oldest first
    t_result     expected_results [$];
    int unsigned n_mismatch;
    int unsigned random_items;
    bit          push_burst;
    bit          pop_burst;

    // one directed character; want is only used where typed is set
    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       url;
        bit         typed;
        t_result    want;
    } t_dir_row;

    // directed walk: extremes of the symbol values, whitespace, padding,
    // invalid characters mid-stream and on the last transfer, empty stream,
    // and the url-safe alphabet with a standard-only symbol as an error
    t_dir_row dir_rows [0:24] = '{
        '{8'h2F, 1'b0, ALPHA_STD, 1'b0, '0},
        '{8'h2F, 1'b0, ALPHA_STD, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},
        '{8'h2F, 1'b0, ALPHA_STD, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},
        '{8'h2F, 1'b0, ALPHA_STD, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},
        '{8'h41, 1'b0, ALPHA_STD, 1'b0, '0},
        '{8'h41, 1'b0, ALPHA_STD, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
        '{8'h2B, 1'b0, ALPHA_STD, 1'b0, '0},
        '{8'h20, 1'b0, ALPHA_STD, 1'b0, '0},
        '{8'h09, 1'b0, ALPHA_STD, 1'b0, '0},
        '{8'h0D, 1'b0, ALPHA_STD, 1'b0, '0},
        '{8'h0A, 1'b0, ALPHA_STD, 1'b0, '0},
        '{8'h7A, 1'b0, ALPHA_STD, 1'b0, '0},
        '{8'h3D, 1'b0, ALPHA_STD, 1'b0, '0},
        '{8'h51, 1'b0, ALPHA_STD, 1'b0, '0},
        '{8'h78, 1'b1, ALPHA_STD, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1}},
        '{8'h00, 1'b0, ALPHA_STD, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
        '{8'h41, 1'b0, ALPHA_STD, 1'b0, '0},
        '{8'hFF, 1'b1, ALPHA_STD, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
        '{8'h2D, 1'b1, ALPHA_STD, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
        '{8'h20, 1'b1, ALPHA_STD, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1}},
        '{8'h2D, 1'b0, ALPHA_URL, 1'b0, '0},
        '{8'h5F, 1'b1, ALPHA_URL, 1'b0, '0},
        '{8'h2B, 1'b1, ALPHA_URL, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
        '{8'h2F, 1'b0, ALPHA_URL, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
        '{8'h39, 1'b1, ALPHA_URL, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}}
    };

    // character class and six-bit value under the selected alphabet
    function automatic t_kind classify(input logic [7:0] ch, input logic url,
                                       output logic [5:0] value);
        value = '0;
        if (ch == CH_PAD) return K_PAD;
        if (ch == CH_SPACE || ch == CH_TAB || ch == CH_CR || ch == CH_LF) return K_SKIP;
        if (ch >= "A" && ch <= "Z") begin
            value = 6'(ch - "A");
            return K_SYM;
        end
        if (ch >= "a" && ch <= "z") begin
            value = 6'(ch - "a" + 26);
            return K_SYM;
        end
        if (ch >= "0" && ch <= "9") begin
            value = 6'(ch - "0" + 52);
            return K_SYM;
        end
        if (ch == (url ? CH_MINUS : CH_PLUS)) begin
            value = 6'd62;
            return K_SYM;
        end
        if (ch == (url ? CH_UNDER : CH_SLASH)) begin
            value = 6'd63;
            return K_SYM;
        end
        return K_BAD;
    endfunction

    // advance the shadow decoder by one character; returns 1 when a result is due
    function automatic bit decode_char(input logic [7:0] ch, input logic last,
                                       output t_result res);
        t_kind       kind;
        logic [5:0]  value;
        int unsigned bits;
        bit          have_byte;
        bit          new_error;
        logic [7:0]  out_byte;
        have_byte = 1'b0;
        new_error = 1'b0;
        out_byte  = '0;
        res       = '0;
        if (!shadow_stopped && !shadow_error) begin
            kind = classify(ch, alphabet_sel, value);
            case (kind)
                K_PAD: begin
                    shadow_stopped = 1'b1;
                end
                K_BAD: begin
                    shadow_error = 1'b1;
                    new_error    = 1'b1;
                end
                K_SYM: begin
                    shadow_acc = {shadow_acc[5:0], value};
                    bits       = shadow_pending + 6;
                    if (bits >= 8) begin
                        out_byte  = 8'(shadow_acc >> (bits - 8));
                        have_byte = 1'b1;
                        bits      = bits - 8;
                    end
                    shadow_pending = 3'(bits);
                end
                default: ;
            endcase
        end
        if (!have_byte && !new_error && !last) return 1'b0;
        res.data_byte     = have_byte ? out_byte : 8'h00;
        res.byte_valid    = have_byte;
        res.decode_error  = shadow_error;
        res.end_of_stream = last;
        if (last) begin
            shadow_acc     = '0;
            shadow_pending = '0;
            shadow_stopped = 1'b0;
            shadow_error   = 1'b0;
        end
        return 1'b1;
    endfunction

    // text character for a six-bit symbol value
    function automatic logic [7:0] symbol_char(input logic [5:0] v, input logic url);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        if (v == 62) return url ? CH_MINUS : CH_PLUS;
        return url ? CH_UNDER : CH_SLASH;
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // symbol of the other alphabet, or any byte at all
    function automatic logic [7:0] stray_char();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, 255));
        if (alphabet_sel == ALPHA_URL)
            return $urandom_range(0, 1) ? CH_PLUS : CH_SLASH;
        return $urandom_range(0, 1) ? CH_MINUS : CH_UNDER;
    endfunction

    // append a result that the block still owes
    task automatic owe_result(input t_result res);
        expected_results = {expected_results, res};
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #(RUN_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // one character transfer; entered and left at a falling edge
    task automatic feed_char(input logic [7:0] ch, input logic last,
                             input bit typed, input t_result want);
        int unsigned pause;
        t_result     res;
        bit          has_res;
        pause = push_burst ? 0 : $urandom_range(0, 4);
        if (pause != 0) begin
            i_push <= 1'b0;
            repeat (pause) @(negedge i_clk);
        end
        i_push      <= 1'b1;
        i_character <= ch;
        i_last_char <= last;
        do @(posedge i_clk); while (o_full !== 1'b0);
        // typed rows carry their result, but the shadow state still has to move
        has_res = decode_char(ch, last, res);
        if (typed)
            owe_result(want);
        else if (has_res)
            owe_result(res);
        @(negedge i_clk);
    endtask

    // alphabet change, only once every owed result is out and the pipe has drained
    task automatic set_alphabet(input logic url);
        i_push <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid    <= 1'b1;
        i_cfg_url_safe <= url;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        alphabet_sel = url;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one random stream: mostly valid symbols with blanks and optional padding,
    // some with a stray character dropped in, some plain noise, some empty
    task automatic send_stream();
        logic [7:0]  chars [$];
        int unsigned mode;
        int unsigned nsym;
        int unsigned bad_at;
        int unsigned i;
        mode = $urandom_range(0, 9);
        if (mode == 8) begin
            repeat ($urandom_range(1, 12)) chars = {chars, 8'($urandom_range(0, 255))};
        end else if (mode != 9) begin
            nsym   = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(0, 12);
            bad_at = (mode == 7) ? $urandom_range(0, nsym) : NO_BAD;
            for (i = 0; i < nsym; i++) begin
                if (i == bad_at) chars = {chars, stray_char()};
                if ($urandom_range(0, 5) == 0) chars = {chars, blank_char()};
                chars = {chars, symbol_char(6'($urandom_range(0, 63)), alphabet_sel)};
            end
            if (bad_at == nsym) chars = {chars, stray_char()};
            if (nsym % 4 != 0 && $urandom_range(0, 1) == 1) begin
                repeat (4 - nsym % 4) chars = {chars, CH_PAD};
                // anything after padding is dropped by the block
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) chars = {chars, 8'($urandom_range(0, 255))};
            end
        end
        if (chars.size() == 0)
            chars = {chars, ($urandom_range(0, 1) ? blank_char() : 8'($urandom_range(0, 255)))};
        push_burst = ($urandom_range(0, 3) == 0);
        for (i = 0; i < chars.size(); i++)
            feed_char(chars[i], i == chars.size() - 1, 1'b0, '0);
        random_items += chars.size();
    endtask

    // character side: reset, directed rows, random streams, drain, verdict
    initial begin : stimulus
        int          r;
        int unsigned n_streams;
        logic        url_next;
        i_rst_n        = 1'b0;
        i_push         = 1'b0;
        i_character    = '0;
        i_last_char    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_url_safe = 1'b0;
        shadow_acc     = '0;
        shadow_pending = '0;
        shadow_stopped = 1'b0;
        shadow_error   = 1'b0;
        alphabet_sel   = ALPHA_STD;
        n_mismatch     = 0;
        random_items   = 0;
        push_burst     = 1'b0;
        n_streams      = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (r = 0; r < $size(dir_rows); r++) begin
            if (dir_rows[r].url !== alphabet_sel) set_alphabet(dir_rows[r].url);
            feed_char(dir_rows[r].ch, dir_rows[r].last, dir_rows[r].typed, dir_rows[r].want);
        end

        // alphabet flips between phases so both values see plenty of traffic
        url_next = 1'($urandom_range(0, 1));
        while (random_items < RANDOM_ITEMS) begin
            if (n_streams % STREAMS_PER_PHASE == 0) begin
                set_alphabet(url_next);
                url_next = ~url_next;
            end
            send_stream();
            n_streams++;
        end

        i_push <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        // give a stray extra result time to show up
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (n_mismatch == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // result side: random stalls per result, compare each transfer with the oldest owed one
    initial begin : result_side
        int unsigned pause;
        t_result     got;
        t_result     want;
        i_pop     = 1'b0;
        pop_burst = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 19) == 0) pop_burst = ~pop_burst;
            pause = pop_burst ? 0 : $urandom_range(0, 4);
            if (pause != 0) begin
                i_pop <= 1'b0;
                repeat (pause) @(negedge i_clk);
            end
            i_pop <= 1'b1;
            do @(posedge i_clk); while (o_empty !== 1'b0);
            got = '{o_data_byte, o_byte_valid, o_decode_error, o_end_of_stream};
            if (expected_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS)
                    $display("unexpected result: byte=%02h valid=%0b err=%0b eos=%0b",
                             got.data_byte, got.byte_valid, got.decode_error,
                             got.end_of_stream);
            end else begin
                want = expected_results.pop_front();
                if (got.data_byte !== want.data_byte || got.byte_valid !== want.byte_valid
                    || got.decode_error !== want.decode_error
                    || got.end_of_stream !== want.end_of_stream) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS)
                        $display("mismatch: exp byte/valid/err/eos %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                                 want.data_byte, want.byte_valid, want.decode_error,
                                 want.end_of_stream, got.data_byte, got.byte_valid,
                                 got.decode_error, got.end_of_stream);
                end
            end
            @(negedge i_clk);
        end
    end

endmodule
